// File: rtl/icrt_pkg.sv
// icrt_pkg: shared types, codes and host-mask helper for the IPv4 CIDR range table.
// No dependencies; imported by every module of the block except icrt_ram.
`timescale 1ns / 1ps

package icrt_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_VERIFY = 2'd3
  } icrt_op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPFX = 2'd1,
    ST_FULL   = 2'd2,
    ST_MISS   = 2'd3
  } icrt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHRD,
    S_SHWR,
    S_PUT,
    S_RESP
  } icrt_state_t;

  // one stored range: masked base, prefix length, overlap-free mark
  typedef struct packed {
    logic [31:0] base;
    logic [5:0]  prefix;
    logic        ok;
  } icrt_entry_t;

  // shared evaluator results
  typedef struct packed {
    logic        a_ge_first;
    logic        a_le_last;
    logic [31:0] last;
  } icrt_cmp_t;

  localparam logic [5:0] PFX_MAX = 6'd32;

  // host bits of a prefix (inverse of the netmask)
  function automatic logic [31:0] host_mask(input logic [5:0] p);
    logic [31:0] m;
    if (p >= PFX_MAX) begin
      m = 32'h0000_0000;
    end else begin
      m = 32'hFFFF_FFFF >> p[4:0];
    end
    return m;
  endfunction

endpackage

// File: rtl/icrt_ram.sv
// icrt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module icrt_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/icrt_eval.sv
// icrt_eval: shared host-bound unit; forms first/last host of one entry and
// compares an operand against them. Depends on icrt_pkg.
`timescale 1ns / 1ps

module icrt_eval import icrt_pkg::*; (
  input  icrt_entry_t ent,
  input  logic [31:0] opnd,
  output icrt_cmp_t   cmp
);

  logic [31:0] first;
  logic [31:0] last;

  // bounds wrap mod 2^32: a /32 has last below first, a /31 has last == base, below first
  assign first = ent.base + 32'd1;
  assign last  = (ent.base | host_mask(ent.prefix)) - 32'd1;

  assign cmp.a_ge_first = (opnd >= first);
  assign cmp.a_le_last  = (opnd <= last);
  assign cmp.last       = last;

endmodule

// File: rtl/ipv4_cidr_range_table.sv
// ipv4_cidr_range_table: sorted CIDR range table with add, lookup, verify, clear.
// Clear and bad prefix go straight to the reply; lookup and verify walk the n entries
// held; add walks them, then shifts each entry at or above the insert point up by one
// and writes the new one. One word in flight; the walk reads one entry per cycle from RAM.
// Sync active-low reset empties the table and drops out_valid; RAM needs no clear.
`timescale 1ns / 1ps

module ipv4_cidr_range_table import icrt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_index,
  output logic        out_entry_ok,
  output logic [6:0]  out_entry_count,
  output logic        out_overlap_found
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(icrt_entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  icrt_state_t state_r, state_nxt;
  icrt_op_t    op_r, op_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [31:0] key_r, key_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          pos_found_r, pos_found_nxt;
  icrt_entry_t   prev_ent_r, prev_ent_nxt;
  logic [31:0]   prev_last_r, prev_last_nxt;
  logic          prev_ov_r, prev_ov_nxt;
  logic          ovl_any_r, ovl_any_nxt;

  icrt_status_t  res_status_r, res_status_nxt;
  logic [CW-1:0] res_idx_r, res_idx_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          res_ov_r, res_ov_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [5:0]    out_index_r;
  logic          out_ok_r;
  logic [6:0]    out_count_r;
  logic          out_ov_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  icrt_entry_t   ram_wdata, rd_ent;
  logic [EW-1:0] ram_rdata;

  icrt_cmp_t     cmp;
  logic [31:0]   opnd;
  logic          accept, walk_end, dup, hit, ov_here, bad_pfx, out_free;
  logic [CW-1:0] idx_inc, idx_dec;
  logic [31:0]   in_base;
  icrt_op_t      in_op;

  icrt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = icrt_entry_t'(ram_rdata);

  always_comb begin
    case (op_r)
      OP_ADD:    opnd = key_r;
      OP_LOOKUP: opnd = addr_r;
      default:   opnd = prev_last_r;
    endcase
  end

  icrt_eval u_eval (
    .ent  (rd_ent),
    .opnd (opnd),
    .cmp  (cmp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_op    = icrt_op_t'(in_operation);
  assign bad_pfx  = !(in_prefix_len inside {[6'd1:PFX_MAX]});
  assign in_base  = in_address & ~host_mask(in_prefix_len);
  assign idx_inc  = idx_r + 1'b1;
  assign idx_dec  = idx_r - 1'b1;
  assign walk_end = (idx_r == count_r);
  assign dup      = !walk_end && (rd_ent.base == addr_r) && (rd_ent.prefix == plen_r);
  assign hit      = !walk_end && cmp.a_ge_first && cmp.a_le_last;
  assign ov_here  = (idx_r != '0) && cmp.a_ge_first;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_CLEAR || (in_op == OP_ADD && bad_pfx)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        case (op_r)
          OP_ADD: begin
            if (dup) begin
              state_nxt = S_RESP;
            end else if (walk_end) begin
              if (count_r >= DEPTH_C) begin
                state_nxt = S_RESP;
              end else if (pos_found_r) begin
                state_nxt = S_SHRD;
              end else begin
                state_nxt = S_PUT;
              end
            end
          end
          OP_LOOKUP: begin
            if (hit || walk_end) begin
              state_nxt = S_RESP;
            end
          end
          default: begin
            if (walk_end) begin
              state_nxt = S_RESP;
            end
          end
        endcase
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: begin
        if (idx_dec > pos_r) begin
          state_nxt = S_SHRD;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    plen_nxt       = plen_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    pos_found_nxt  = pos_found_r;
    prev_ent_nxt   = prev_ent_r;
    prev_last_nxt  = prev_last_r;
    prev_ov_nxt    = prev_ov_r;
    ovl_any_nxt    = ovl_any_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ok_nxt     = res_ok_r;
    res_ov_nxt     = res_ov_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = rd_ent;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          addr_nxt       = (in_op == OP_ADD) ? in_base : in_address;
          plen_nxt       = in_prefix_len;
          key_nxt        = in_base + 32'd1;
          idx_nxt        = '0;
          pos_found_nxt  = 1'b0;
          prev_ov_nxt    = 1'b0;
          ovl_any_nxt    = 1'b0;
          res_status_nxt = ST_DONE;
          res_idx_nxt    = '0;
          res_ok_nxt     = 1'b0;
          res_ov_nxt     = 1'b0;
          if (in_op == OP_CLEAR) begin
            count_nxt = '0;
          end else if (in_op == OP_ADD && bad_pfx) begin
            res_status_nxt = ST_BADPFX;
          end
        end
      end
      S_WALK: begin
        ram_raddr = idx_inc[AW-1:0];
        idx_nxt   = idx_inc;
        case (op_r)
          OP_ADD: begin
            if (!walk_end && !pos_found_r && !cmp.a_ge_first) begin
              pos_nxt       = idx_r;
              pos_found_nxt = 1'b1;
            end
            if (dup) begin
              res_idx_nxt = idx_r;
              res_ok_nxt  = rd_ent.ok;
            end else if (walk_end) begin
              idx_nxt = count_r;
              if (count_r >= DEPTH_C) begin
                res_status_nxt = ST_FULL;
              end else if (!pos_found_r) begin
                pos_nxt = count_r;
              end
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              res_idx_nxt = idx_r;
              res_ok_nxt  = rd_ent.ok;
            end else if (walk_end) begin
              res_status_nxt = ST_MISS;
            end
          end
          default: begin
            ram_waddr = idx_dec[AW-1:0];
            ram_wdata = prev_ent_r;
            if (walk_end) begin
              // close out the last entry: it has no successor
              ram_we       = (count_r != '0);
              ram_wdata.ok = !prev_ov_r;
              res_ov_nxt   = ovl_any_r;
            end else begin
              // mark of the previous entry is known once its successor is seen
              ram_we        = (idx_r != '0);
              ram_wdata.ok  = !(prev_ov_r || ov_here);
              prev_ent_nxt  = rd_ent;
              prev_last_nxt = cmp.last;
              prev_ov_nxt   = ov_here;
              ovl_any_nxt   = ovl_any_r || ov_here;
            end
          end
        endcase
      end
      S_SHRD: begin
        ram_raddr = idx_dec[AW-1:0];
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = rd_ent;
        idx_nxt   = idx_dec;
      end
      S_PUT: begin
        ram_we           = 1'b1;
        ram_waddr        = pos_r[AW-1:0];
        ram_wdata.base   = addr_r;
        ram_wdata.prefix = plen_r;
        ram_wdata.ok     = 1'b1;
        count_nxt        = count_r + 1'b1;
        res_idx_nxt      = pos_r;
        res_ok_nxt       = 1'b1;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    plen_r       <= plen_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    pos_found_r  <= pos_found_nxt;
    prev_ent_r   <= prev_ent_nxt;
    prev_last_r  <= prev_last_nxt;
    prev_ov_r    <= prev_ov_nxt;
    ovl_any_r    <= ovl_any_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ok_r     <= res_ok_nxt;
    res_ov_r     <= res_ov_nxt;
    if (state_r == S_RESP && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= 6'(res_idx_r);
      out_ok_r     <= res_ok_r;
      out_count_r  <= 7'(count_r);
      out_ov_r     <= res_ov_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_index   = out_index_r;
  assign out_entry_ok      = out_ok_r;
  assign out_entry_count   = out_count_r;
  assign out_overlap_found = out_ov_r;

endmodule

// File: rtl/icrt_chk.sv
// icrt_chk: port-level checks for the range table, bound to the top level.
// Depends on icrt_pkg and ipv4_cidr_range_table.
`timescale 1ns / 1ps

module icrt_chk import icrt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [5:0]  out_entry_index,
  input logic        out_entry_ok,
  input logic [6:0]  out_entry_count,
  input logic        out_overlap_found
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_index) && $stable(out_entry_ok) &&
      $stable(out_entry_count) && $stable(out_overlap_found))
    else $error("result word changed while stalled");

  // one word in flight: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word in progress");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == 7'(TABLE_DEPTH) &&
      out_entry_index == 6'd0 && !out_entry_ok)
    else $error("table full reported below depth");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS || out_status == ST_BADPFX) |->
      out_entry_index == 6'd0 && !out_entry_ok && !out_overlap_found)
    else $error("miss or bad prefix carries entry data");

endmodule

bind ipv4_cidr_range_table icrt_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_icrt_chk (.*);

// File: test/ipv4_cidr_range_table_tb.sv
// ipv4_cidr_range_table_tb: self-checking bench for the sorted CIDR range table.
// It predicts every reply word, checks replies in order and uses random bursts and stalls.
// Depends on icrt_pkg and the ipv4_cidr_range_table RTL.
`timescale 1ns / 1ps

module ipv4_cidr_range_table_tb;
  import icrt_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    icrt_op_t    op;
    logic [31:0] addr;
    logic [5:0]  pfx;
  } cmd_t;

  typedef struct {
    icrt_status_t status;
    logic [5:0]   index;
    logic         ok;
    logic [6:0]   count;
    logic         overlap;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = 2'd0;
  logic [31:0] in_address = 32'd0;
  logic [5:0]  in_prefix_len = 6'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_entry_index;
  logic        out_entry_ok;
  logic [6:0]  out_entry_count;
  logic        out_overlap_found;

  cmd_t   queued_words[$];
  reply_t awaited_replies[$];
  int     err_count = 0;

  // shadow copy of the range table
  logic [31:0] tbl_base [DEPTH];
  logic [5:0]  tbl_pfx  [DEPTH];
  bit          tbl_ok   [DEPTH];
  int          tbl_used;

  always #4 clk = ~clk;

  ipv4_cidr_range_table #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_prefix_len    (in_prefix_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_index  (out_entry_index),
    .out_entry_ok     (out_entry_ok),
    .out_entry_count  (out_entry_count),
    .out_overlap_found(out_overlap_found)
  );

  function automatic logic [31:0] prefix_netmask(logic [5:0] p);
    if (p >= 6'd32) begin
      return 32'hFFFF_FFFF;
    end
    return 32'hFFFF_FFFF << (6'd32 - p);
  endfunction

  // last usable host, wraps mod 2^32 (a /32 gives base-1)
  function automatic logic [31:0] last_host_of(int i);
    return (tbl_base[i] | ~prefix_netmask(tbl_pfx[i])) - 32'd1;
  endfunction

  function automatic reply_t cidr_table_apply(logic [1:0] op, logic [31:0] addr,
                                              logic [5:0] pfx);
    reply_t      r;
    logic [31:0] base;
    logic [31:0] key;
    int          pos;
    int          i;
    r.status  = ST_DONE;
    r.index   = '0;
    r.ok      = 1'b0;
    r.overlap = 1'b0;
    case (icrt_op_t'(op))
      OP_CLEAR: begin
        for (i = 0; i < DEPTH; i++) tbl_ok[i] = 1'b1;
        tbl_used = 0;
      end
      OP_ADD: begin
        if (pfx == 6'd0 || pfx > 6'd32) begin
          r.status = ST_BADPFX;
        end else begin
          base = addr & prefix_netmask(pfx);
          pos = -1;
          for (i = 0; i < tbl_used; i++) begin
            if (pos < 0 && tbl_base[i] == base && tbl_pfx[i] == pfx) pos = i;
          end
          if (pos >= 0) begin
            r.index = pos[5:0];
            r.ok    = tbl_ok[pos];
          end else if (tbl_used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // insert after every entry whose first host is not above the new one
            key = base + 32'd1;
            pos = tbl_used;
            for (i = tbl_used - 1; i >= 0; i--) begin
              if (tbl_base[i] + 32'd1 > key) pos = i;
            end
            for (i = tbl_used; i > pos; i--) begin
              tbl_base[i] = tbl_base[i-1];
              tbl_pfx[i]  = tbl_pfx[i-1];
              tbl_ok[i]   = tbl_ok[i-1];
            end
            tbl_base[pos] = base;
            tbl_pfx[pos]  = pfx;
            tbl_ok[pos]   = 1'b1;
            tbl_used++;
            r.index = pos[5:0];
            r.ok    = 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        r.status = ST_MISS;
        for (i = 0; i < tbl_used; i++) begin
          if (r.status == ST_MISS && addr >= tbl_base[i] + 32'd1 && addr <= last_host_of(i)) begin
            r.status = ST_DONE;
            r.index  = i[5:0];
            r.ok     = tbl_ok[i];
          end
        end
      end
      default: begin
        for (i = 0; i < tbl_used; i++) tbl_ok[i] = 1'b1;
        for (i = 0; i + 1 < tbl_used; i++) begin
          if (last_host_of(i) >= tbl_base[i+1] + 32'd1) begin
            tbl_ok[i]   = 1'b0;
            tbl_ok[i+1] = 1'b0;
            r.overlap   = 1'b1;
          end
        end
      end
    endcase
    r.count = tbl_used[6:0];
    return r;
  endfunction

  task automatic queue_word(icrt_op_t op, logic [31:0] addr, logic [5:0] pfx);
    cmd_t c;
    c.op   = op;
    c.addr = addr;
    c.pfx  = pfx;
    queued_words.push_back(c);
  endtask

  // sender: bursts of words separated by random gaps
  int   burst_left = 1;
  int   gap_left = 0;
  cmd_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_replies.push_back(cidr_table_apply(in_operation, in_address, in_prefix_len));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || queued_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_word = queued_words.pop_front();
          in_valid      <= 1'b1;
          in_operation  <= next_word.op;
          in_address    <= next_word.addr;
          in_prefix_len <= next_word.pfx;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // receiver: out_ready follows a stall mode that is picked anew at random
  int stall_mode = 0;
  int stall_left = 0;
  int ready_tick = 0;

  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= (ready_tick % 7 < 3);
    endcase
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        err_count++;
        $display("%0t: unexpected reply word, expected none, got status %0d index %0d",
                 $time, out_status, out_entry_index);
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status) begin
          err_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
        if (out_entry_index !== want.index) begin
          err_count++;
          $display("%0t: entry_index expected %0d got %0d", $time, want.index, out_entry_index);
        end
        if (out_entry_ok !== want.ok) begin
          err_count++;
          $display("%0t: entry_ok expected %0d got %0d", $time, want.ok, out_entry_ok);
        end
        if (out_entry_count !== want.count) begin
          err_count++;
          $display("%0t: entry_count expected %0d got %0d", $time, want.count, out_entry_count);
        end
        if (out_overlap_found !== want.overlap) begin
          err_count++;
          $display("%0t: overlap_found expected %0d got %0d", $time, want.overlap,
                   out_overlap_found);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int          k;
    int          span;
    int          pick;
    int          sel;
    int          j;
    bit          fill;
    logic [31:0] a;
    logic [31:0] hub;
    logic [31:0] spread;
    logic [31:0] m;
    logic [31:0] b;
    logic [5:0]  p;
    logic [31:0] pool_addr[$];
    logic [5:0]  pool_pfx[$];

    for (k = 0; k < DEPTH; k++) tbl_ok[k] = 1'b1;
    tbl_used = 0;

    // directed: empty table, bad prefixes, duplicates, /31 and /32 wrap, overlaps
    queue_word(OP_LOOKUP, 32'h0A00_0001, 6'd0);
    queue_word(OP_VERIFY, 32'h0000_0000, 6'd0);
    queue_word(OP_ADD,    32'h0A00_0000, 6'd8);
    queue_word(OP_ADD,    32'h0B00_0000, 6'd0);
    queue_word(OP_ADD,    32'h0B00_0000, 6'd33);
    queue_word(OP_ADD,    32'hFFFF_FFFF, 6'd63);
    queue_word(OP_ADD,    32'h0A12_3456, 6'd8);
    queue_word(OP_ADD,    32'hFFFF_FFFF, 6'd32);
    queue_word(OP_ADD,    32'h0000_0000, 6'd1);
    queue_word(OP_ADD,    32'hC0A8_0001, 6'd31);
    queue_word(OP_ADD,    32'h0A01_0000, 6'd16);
    queue_word(OP_LOOKUP, 32'h0A01_0203, 6'd0);
    queue_word(OP_LOOKUP, 32'hC0A8_0000, 6'd0);
    queue_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    queue_word(OP_LOOKUP, 32'h0A00_0000, 6'd0);
    queue_word(OP_VERIFY, 32'hFFFF_FFFF, 6'd63);
    queue_word(OP_LOOKUP, 32'h0A00_00FF, 6'd0);
    queue_word(OP_ADD,    32'h8000_0000, 6'd1);
    queue_word(OP_ADD,    32'h1234_5678, 6'd32);
    queue_word(OP_ADD,    32'h1234_5678, 6'd32);
    queue_word(OP_VERIFY, 32'h0000_0000, 6'd0);
    queue_word(OP_CLEAR,  32'hFFFF_FFFF, 6'd63);
    queue_word(OP_LOOKUP, 32'h0A00_0001, 6'd0);
    queue_word(OP_ADD,    32'hFFFF_FFFF, 6'd2);
    queue_word(OP_VERIFY, 32'h0000_0000, 6'd0);

    // random sessions: clustered adds, duplicates, edge lookups, some fill past full
    while (queued_words.size() < 1225) begin
      if ($urandom_range(0, 4) != 0) queue_word(OP_CLEAR, $urandom, 6'($urandom_range(0, 63)));
      fill   = ($urandom_range(0, 5) == 0);
      span   = fill ? $urandom_range(72, 90) : $urandom_range(4, 30);
      hub    = $urandom;
      spread = 32'hFFFF_FFFF >> $urandom_range(8, 28);
      pool_addr.delete();
      pool_pfx.delete();
      for (k = 0; k < span; k++) begin
        pick = $urandom_range(0, 99);
        if (fill && pick < 75) pick = 0;
        if (pick < 45) begin
          sel = $urandom_range(0, 19);
          if (sel < 2) begin
            a = $urandom;
            p = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
          end else if (sel < 6 && pool_addr.size() > 0) begin
            // same range again, host bits changed
            j = $urandom_range(0, pool_addr.size() - 1);
            p = pool_pfx[j];
            a = pool_addr[j] ^ ($urandom & ~prefix_netmask(p));
          end else begin
            p = (sel < 9) ? 6'($urandom_range(1, 15)) : 6'($urandom_range(16, 32));
            a = (sel < 16) ? (hub ^ ($urandom & spread)) : $urandom;
            pool_addr.push_back(a);
            pool_pfx.push_back(p);
          end
          queue_word(OP_ADD, a, p);
        end else if (pick < 80) begin
          if (pool_addr.size() > 0 && $urandom_range(0, 9) < 7) begin
            j = $urandom_range(0, pool_addr.size() - 1);
            m = prefix_netmask(pool_pfx[j]);
            b = pool_addr[j] & m;
            case ($urandom_range(0, 5))
              0: a = b;
              1: a = b + 32'd1;
              2: a = (b | ~m) - 32'd1;
              3: a = b | ~m;
              default: a = b | ($urandom & ~m);
            endcase
          end else begin
            a = $urandom_range(0, 1) ? (hub ^ ($urandom & spread)) : $urandom;
          end
          queue_word(OP_LOOKUP, a, 6'($urandom_range(0, 63)));
        end else if (pick < 92) begin
          queue_word(OP_VERIFY, $urandom, 6'($urandom_range(0, 63)));
        end else begin
          queue_word(icrt_op_t'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (queued_words.size() != 0 || in_valid || awaited_replies.size() != 0) begin
      @(negedge clk);
    end
    // longest item is an add at the front of a 63-entry table
    repeat (250) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
